// ===== rtl/bfsc_pkg.sv =====
// Package for the bitmap find-first-set/clear block: payload structs,
// operation and register codes, and the lowest-one encoder.
// No dependencies.
package bfsc_pkg;

   localparam int NBITS_DEFAULT     = 1024;
   localparam int WORD_BITS_DEFAULT = 64;

   localparam int KIND_W   = 3;
   localparam int INDEX_W  = 10;
   localparam int COUNT_W  = 11;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

   // operation codes
   localparam logic [KIND_W-1:0] KIND_SET       = 3'd0;
   localparam logic [KIND_W-1:0] KIND_CLEAR     = 3'd1;
   localparam logic [KIND_W-1:0] KIND_TEST      = 3'd2;
   localparam logic [KIND_W-1:0] KIND_SET_ALL   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CLEAR_ALL = 3'd4;

   // register index (paddr word bit)
   localparam logic REG_BIT_COUNT = 1'b0;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [INDEX_W-1:0] bit_index;
   } req_type;

   typedef struct packed {
      logic               bit_value;
      logic               found_set;
      logic [INDEX_W-1:0] first_set_index;
      logic               found_clear;
      logic [INDEX_W-1:0] first_clear_index;
      logic               all_set;
      logic               all_clear;
      logic               index_out_of_range;
   } rsp_type;

   typedef struct packed {
      logic               found_set;
      logic [INDEX_W-1:0] first_set_index;
      logic               found_clear;
      logic [INDEX_W-1:0] first_clear_index;
      logic               all_set;
      logic               all_clear;
   } search_type;

   // Lowest set bit of a 64-bit word: pick the lowest nonzero byte, then the
   // lowest bit within it. Returns zero for an all-zero word.
   function automatic logic [5:0] lowest_one64(input logic [63:0] x);
      logic [7:0] grp;
      logic [7:0] sel;
      logic [2:0] g;
      logic [2:0] b;
      for (int i = 0; i < 8; i++) begin
         grp[i] = |x[8*i +: 8];
      end
      g = 3'd0;
      for (int i = 7; i >= 0; i--) begin
         if (grp[i]) begin
            g = 3'(i);
         end
      end
      sel = x[8*g +: 8];
      b = 3'd0;
      for (int i = 7; i >= 0; i--) begin
         if (sel[i]) begin
            b = 3'(i);
         end
      end
      return {g, b};
   endfunction

endpackage

// ===== rtl/bfsc_mem.sv =====
// Bitmap word store: one write port, one read port, registered read data.
// No dependencies.
module bfsc_mem #(
   parameter int WORD_BITS = 64,
   parameter int DEPTH     = 16,
   localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  logic [WORD_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [AW-1:0]        rd_addr,
   output logic [WORD_BITS-1:0] rd_data
);

   logic [WORD_BITS-1:0] mem [DEPTH];
   logic [WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bfsc_search.sv =====
// Search stage: encodes the lowest one of each masked word and folds it into
// the running first-set / first-clear / all-set / all-clear result.
// Depends on bfsc_pkg.
module bfsc_search #(
   parameter int WORD_BITS = 64,
   parameter int BASE_W    = 12
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    word_vld,
   input  logic [WORD_BITS-1:0]    ones,
   input  logic [WORD_BITS-1:0]    zeros,
   input  logic [BASE_W-1:0]       base,
   output bfsc_pkg::search_type    result
);

   bfsc_pkg::search_type acc_ff, acc_in;
   logic [5:0]        lo_set, lo_clear;
   logic [BASE_W-1:0] sum_set, sum_clear;

   assign lo_set    = bfsc_pkg::lowest_one64(64'(ones));
   assign lo_clear  = bfsc_pkg::lowest_one64(64'(zeros));
   assign sum_set   = base + BASE_W'(lo_set);
   assign sum_clear = base + BASE_W'(lo_clear);

   always_comb begin
      acc_in = acc_ff;
      if (start) begin
         acc_in = '0;
         acc_in.all_set   = 1'b1;
         acc_in.all_clear = 1'b1;
      end else if (word_vld) begin
         if (|ones) begin
            acc_in.all_clear = 1'b0;
            if (!acc_ff.found_set) begin
               acc_in.found_set       = 1'b1;
               acc_in.first_set_index = sum_set[bfsc_pkg::INDEX_W-1:0];
            end
         end
         if (|zeros) begin
            acc_in.all_set = 1'b0;
            if (!acc_ff.found_clear) begin
               acc_in.found_clear       = 1'b1;
               acc_in.first_clear_index = sum_clear[bfsc_pkg::INDEX_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   assign result = acc_ff;

endmodule

// ===== rtl/bitmap_find_first_set_clear.sv =====
// Top level of the bitmap find-first-set/clear block: handshake, register
// port, scan sequencer and read-modify-write of the bitmap words.
// Depends on bfsc_pkg, bfsc_mem and bfsc_search.
//
//   port group | direction | handshake        | beat
//   -----------+-----------+------------------+--------------------------------
//   req_       | in        | req_valid/ready  | kind, bit_index
//   rsp_       | out       | rsp_valid/ready  | bit value, first set/clear, flags
//   APB        | in/out    | psel/penable     | bit_count register at address 0
//
// Every item sweeps all NWORDS words of the store through one read port,
// one word per cycle, and the next request beat is taken only after the
// sweep has passed its result on and the sequencer is idle again. After
// reset a clearing pass writes zero to each word, with req_ready low. A
// request beat may be taken while a response beat still waits; the sweep
// holds its result in the last step until the output register is free.
module bitmap_find_first_set_clear #(
   parameter int NBITS     = bfsc_pkg::NBITS_DEFAULT,
   parameter int WORD_BITS = bfsc_pkg::WORD_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  bfsc_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output bfsc_pkg::rsp_type                   rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [bfsc_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [bfsc_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [bfsc_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   localparam int NWORDS = (NBITS + WORD_BITS - 1) / WORD_BITS;
   localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
   localparam int SHW    = $clog2(WORD_BITS);
   localparam int BW_A   = $clog2(NBITS + WORD_BITS) + 1;
   localparam int BW_B   = bfsc_pkg::COUNT_W + 1;
   localparam int BASE_W = (BW_A > BW_B) ? BW_A : BW_B;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   localparam logic [WORD_BITS-1:0] FULL = {WORD_BITS{1'b1}};

   // ------------------------------------------------------------------
   // Register port
   // ------------------------------------------------------------------
   logic [bfsc_pkg::COUNT_W-1:0] bit_count_ff;
   logic                         csr_wr;
   logic                         csr_sel;

   assign pready  = 1'b1;
   assign csr_sel = (paddr[bfsc_pkg::CSR_ADDR_W-1] == bfsc_pkg::REG_BIT_COUNT);
   assign csr_wr  = psel & penable & pwrite & pready;
   assign prdata  = csr_sel
                  ? {(bfsc_pkg::CSR_DATA_W - bfsc_pkg::COUNT_W)'(0), bit_count_ff}
                  : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_count_ff <= bfsc_pkg::COUNT_RESET;
      end else if (csr_wr && csr_sel) begin
         bit_count_ff <= pwdata[bfsc_pkg::COUNT_W-1:0];
      end
   end

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   logic [2:0]              state_ff, state_in;
   logic [AW-1:0]           scan_idx_ff, scan_idx_in;
   logic [BASE_W-1:0]       base_ff, base_in;
   logic                    req_fire, rsp_load, last_word;
   logic                    s1_vld_ff, s2_vld_ff;

   // captured item
   logic [bfsc_pkg::KIND_W-1:0] kind_ff;
   logic [BASE_W-1:0]           idx_ff;
   logic [BASE_W-1:0]           used_ff;
   logic                        in_range_ff;
   logic                        bv_ff;

   logic [BASE_W-1:0]       count_ext, used_now, idx_now;

   assign count_ext = BASE_W'(bit_count_ff);
   assign used_now  = (count_ext > BASE_W'(NBITS)) ? BASE_W'(NBITS) : count_ext;
   assign idx_now   = BASE_W'(req_data.bit_index);

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign last_word = (scan_idx_ff == AW'(NWORDS - 1));
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid || rsp_ready);

   always_comb begin
      state_in    = state_ff;
      scan_idx_in = scan_idx_ff;
      base_in     = base_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (last_word) begin
               state_in    = ST_IDLE;
               scan_idx_in = '0;
            end else begin
               scan_idx_in = scan_idx_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               state_in    = ST_SCAN;
               scan_idx_in = '0;
               base_in     = '0;
            end
         end
         ST_SCAN: begin
            if (last_word) begin
               state_in = ST_DRAIN;
            end else begin
               scan_idx_in = scan_idx_ff + AW'(1);
               base_in     = base_ff + BASE_W'(WORD_BITS);
            end
         end
         ST_DRAIN: begin
            // advance once the last word leaves the search stage
            if (s2_vld_ff && !s1_vld_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         scan_idx_ff <= '0;
         base_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         scan_idx_ff <= scan_idx_in;
         base_ff     <= base_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         kind_ff     <= req_data.kind;
         idx_ff      <= idx_now;
         used_ff     <= used_now;
         in_range_ff <= (idx_now < used_now);
      end
   end

   // ------------------------------------------------------------------
   // Issue: address the word and work out its tail mask and bit hit
   // ------------------------------------------------------------------
   logic                 issue;
   logic [BASE_W-1:0]    rem, off_diff;
   logic [WORD_BITS-1:0] mask_issue;
   logic                 hit_issue;

   assign issue    = (state_ff == ST_SCAN);
   assign rem      = used_ff - base_ff;
   assign off_diff = idx_ff - base_ff;
   assign hit_issue = (idx_ff >= base_ff) && (idx_ff < base_ff + BASE_W'(WORD_BITS));

   always_comb begin
      if (base_ff >= used_ff) begin
         mask_issue = '0;
      end else if (rem >= BASE_W'(WORD_BITS)) begin
         mask_issue = FULL;
      end else begin
         mask_issue = ~(FULL << rem[SHW-1:0]);
      end
   end

   logic [AW-1:0]        s1_addr_ff;
   logic [BASE_W-1:0]    s1_base_ff;
   logic                 s1_hit_ff;
   logic [SHW-1:0]       s1_off_ff;
   logic [WORD_BITS-1:0] s1_mask_ff;

   always_ff @(posedge clock) begin
      s1_addr_ff <= scan_idx_ff;
      s1_base_ff <= base_ff;
      s1_hit_ff  <= hit_issue;
      s1_off_ff  <= off_diff[SHW-1:0];
      s1_mask_ff <= mask_issue;
   end

   // ------------------------------------------------------------------
   // Word store
   // ------------------------------------------------------------------
   logic                 mem_wr_en;
   logic [AW-1:0]        mem_wr_addr;
   logic [WORD_BITS-1:0] mem_wr_data, rd_word, new_word;

   bfsc_mem #(
      .WORD_BITS (WORD_BITS),
      .DEPTH     (NWORDS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (issue),
      .rd_addr (scan_idx_ff),
      .rd_data (rd_word)
   );

   // ------------------------------------------------------------------
   // Modify and write back. Each sweep touches every word once, and the
   // next item's first read comes after this item's last write lands.
   // ------------------------------------------------------------------
   always_comb begin
      new_word = rd_word;
      case (kind_ff)
         bfsc_pkg::KIND_SET_ALL: begin
            new_word = FULL;
         end
         bfsc_pkg::KIND_CLEAR_ALL: begin
            new_word = '0;
         end
         bfsc_pkg::KIND_SET: begin
            if (in_range_ff && s1_hit_ff) begin
               new_word = rd_word | (WORD_BITS'(1) << s1_off_ff);
            end
         end
         bfsc_pkg::KIND_CLEAR: begin
            if (in_range_ff && s1_hit_ff) begin
               new_word = rd_word & ~(WORD_BITS'(1) << s1_off_ff);
            end
         end
         default: begin
            new_word = rd_word;
         end
      endcase
   end

   always_comb begin
      if (state_ff == ST_CLEAR) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = scan_idx_ff;
         mem_wr_data = '0;
      end else begin
         mem_wr_en   = s1_vld_ff;
         mem_wr_addr = s1_addr_ff;
         mem_wr_data = new_word;
      end
   end

   logic [WORD_BITS-1:0] s2_ones_ff, s2_zeros_ff;
   logic [BASE_W-1:0]    s2_base_ff;

   always_ff @(posedge clock) begin
      s2_ones_ff  <= new_word & s1_mask_ff;
      s2_zeros_ff <= ~new_word & s1_mask_ff;
      s2_base_ff  <= s1_base_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         bv_ff     <= 1'b0;
      end else begin
         s1_vld_ff <= issue;
         s2_vld_ff <= s1_vld_ff;
         if (req_fire) begin
            bv_ff <= 1'b0;
         end else if (s1_vld_ff && s1_hit_ff && in_range_ff) begin
            // addressed bit as it stands after the operation
            bv_ff <= new_word[s1_off_ff];
         end
      end
   end

   // ------------------------------------------------------------------
   // Search and response
   // ------------------------------------------------------------------
   bfsc_pkg::search_type srch;
   bfsc_pkg::rsp_type    rsp_ff;
   logic                 rsp_valid_ff;
   logic                 is_all;

   bfsc_search #(
      .WORD_BITS (WORD_BITS),
      .BASE_W    (BASE_W)
   ) u_search (
      .clock    (clock),
      .reset    (reset),
      .start    (req_fire),
      .word_vld (s2_vld_ff),
      .ones     (s2_ones_ff),
      .zeros    (s2_zeros_ff),
      .base     (s2_base_ff),
      .result   (srch)
   );

   assign is_all = (kind_ff == bfsc_pkg::KIND_SET_ALL) ||
                   (kind_ff == bfsc_pkg::KIND_CLEAR_ALL);

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff.bit_value          <= bv_ff;
         rsp_ff.found_set          <= srch.found_set;
         rsp_ff.first_set_index    <= srch.first_set_index;
         rsp_ff.found_clear        <= srch.found_clear;
         rsp_ff.first_clear_index  <= srch.first_clear_index;
         rsp_ff.all_set            <= srch.all_set;
         rsp_ff.all_clear          <= srch.all_clear;
         rsp_ff.index_out_of_range <= !is_all && !in_range_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/bfsc_checker.sv =====
// Port-level checks for the bitmap find-first-set/clear block, bound to the
// top level. Depends on bfsc_pkg and bitmap_find_first_set_clear.
module bfsc_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input bfsc_pkg::rsp_type                rsp_data,
   input logic                             psel,
   input logic                             penable,
   input logic                             pwrite,
   input logic [bfsc_pkg::CSR_ADDR_W-1:0]  paddr,
   input logic [bfsc_pkg::CSR_DATA_W-1:0]  pwdata,
   input logic [bfsc_pkg::CSR_DATA_W-1:0]  prdata,
   input logic                             pready
);

   // hold a stalled response beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response beat changed while stalled");

   // one item at a time: drop ready right after a request beat
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while an item is in flight");

   // a new response comes only from a finished sweep
   a_rsp_after_sweep: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response appeared while idle");

   // a written bit_count reads back
   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      psel && penable && pwrite && pready && (paddr[bfsc_pkg::CSR_ADDR_W-1] ==
      bfsc_pkg::REG_BIT_COUNT) |=> (paddr[bfsc_pkg::CSR_ADDR_W-1] !=
      bfsc_pkg::REG_BIT_COUNT) || (prdata[bfsc_pkg::COUNT_W-1:0] ==
      $past(pwdata[bfsc_pkg::COUNT_W-1:0])))
      else $error("bit_count readback mismatch");

   a_pready: assert property (@(posedge clock) disable iff (reset) pready)
      else $error("pready low");

endmodule

bind bitmap_find_first_set_clear bfsc_checker u_bfsc_checker (.*);
